// ----- design/rpchc_pkg.sv -----
package rpchc_pkg;

	localparam int unsigned MaxReplyBytes = 65536;
	localparam int unsigned ByteW = 8;
	localparam int unsigned XidW = 32;
	localparam int unsigned WordW = 32;
	localparam int unsigned AsmW = 24;
	localparam int unsigned SkipW = 33;
	localparam int unsigned StatusW = 2;
	localparam int unsigned OffsetW = 17;
	localparam int unsigned OutDataW = 24;

	localparam logic [XidW-1:0] XidReset = 32'd1;
	localparam logic [WordW-1:0] DirReply = 32'd1;
	localparam logic [WordW-1:0] RstatAccepted = 32'd0;
	localparam logic [WordW-1:0] RstatDenied = 32'd1;
	localparam logic [WordW-1:0] AcceptSuccess = 32'd0;
	localparam logic [SkipW-1:0] PadAdd = 33'd3;
	localparam logic [SkipW-1:0] PadMask = ~33'd3;
	localparam logic [1:0] LastByteOfWord = 2'd3;

	typedef enum logic [StatusW-1:0] {
		STATUS_OK          = 2'd0,
		STATUS_DENIED      = 2'd1,
		STATUS_ACCEPT_FAIL = 2'd2,
		STATUS_MALFORMED   = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		STAGE_XID    = 7'b0000001,
		STAGE_DIR    = 7'b0000010,
		STAGE_RSTAT  = 7'b0000100,
		STAGE_FLAVOR = 7'b0001000,
		STAGE_VLEN   = 7'b0010000,
		STAGE_SKIP   = 7'b0100000,
		STAGE_ACCEPT = 7'b1000000
	} stage_t;

	typedef struct packed {
		logic                data_valid;
		logic [ByteW-1:0]    data_byte;
		logic                last_byte;
	} in_item_t;

	typedef struct packed {
		logic                valid;
		status_t             status;
		logic [OffsetW-1:0]  body_offset;
	} result_t;

endpackage

// ----- design/rpchc_in_stage.sv -----
module rpchc_in_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [rpchc_pkg::ByteW-1:0]         s_axis_tdata,
	input  logic                                s_axis_tlast,
	input  logic                                advance,
	output rpchc_pkg::in_item_t                 item
);

	logic                         valid_s1;
	logic [rpchc_pkg::ByteW-1:0]  byte_s1;
	logic                         last_s1;

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign item.data_valid = valid_s1;
	assign item.data_byte  = byte_s1;
	assign item.last_byte  = last_s1;

endmodule

// ----- design/rpchc_parser.sv -----
module rpchc_parser #(
	parameter int unsigned MAX_REPLY_BYTES = rpchc_pkg::MaxReplyBytes
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpchc_pkg::in_item_t           item,
	input  logic                          advance,
	input  logic [rpchc_pkg::XidW-1:0]    match_xid,
	output rpchc_pkg::result_t            result
);

	localparam int unsigned PosW = $clog2(MAX_REPLY_BYTES + 1);

	rpchc_pkg::stage_t                 stage_q, stage_d;
	logic [rpchc_pkg::AsmW-1:0]        asm_q, asm_d;
	logic [1:0]                        biw_q, biw_d;
	logic [rpchc_pkg::SkipW-1:0]       skip_q, skip_d;
	logic [PosW-1:0]                   pos_q, pos_d;
	logic                              decided_q, decided_d;

	logic [rpchc_pkg::WordW-1:0]       word;
	logic [rpchc_pkg::SkipW-1:0]       padded;
	logic [PosW-1:0]                   pos_inc;
	logic [PosW+rpchc_pkg::OffsetW-1:0] pos_ext;
	logic                              res_vld;
	rpchc_pkg::status_t                res_stat;

	assign word    = {asm_q, item.data_byte};
	assign padded  = ({1'b0, word} + rpchc_pkg::PadAdd) & rpchc_pkg::PadMask;
	assign pos_inc = pos_q + PosW'(1);
	assign pos_ext = {{rpchc_pkg::OffsetW{1'b0}}, pos_inc};

	always_comb begin
		stage_d   = stage_q;
		asm_d     = asm_q;
		biw_d     = biw_q;
		skip_d    = skip_q;
		pos_d     = pos_q;
		decided_d = decided_q;
		res_vld   = 1'b0;
		res_stat  = rpchc_pkg::STATUS_MALFORMED;
		if (!decided_q) begin
			if (pos_q >= PosW'(MAX_REPLY_BYTES)) begin
				res_vld = 1'b1;
			end else begin
				pos_d = pos_inc;
				if (stage_q == rpchc_pkg::STAGE_SKIP) begin
					skip_d = skip_q - rpchc_pkg::SkipW'(1);
					if (skip_q == rpchc_pkg::SkipW'(1)) begin
						stage_d = rpchc_pkg::STAGE_ACCEPT;
					end
				end else if (biw_q != rpchc_pkg::LastByteOfWord) begin
					asm_d = {asm_q[rpchc_pkg::AsmW-rpchc_pkg::ByteW-1:0], item.data_byte};
					biw_d = biw_q + 2'd1;
				end else begin
					asm_d = '0;
					biw_d = 2'd0;
					case (stage_q)
						rpchc_pkg::STAGE_XID: begin
							if (word != match_xid) res_vld = 1'b1;
							else stage_d = rpchc_pkg::STAGE_DIR;
						end
						rpchc_pkg::STAGE_DIR: begin
							if (word != rpchc_pkg::DirReply) res_vld = 1'b1;
							else stage_d = rpchc_pkg::STAGE_RSTAT;
						end
						rpchc_pkg::STAGE_RSTAT: begin
							if (word == rpchc_pkg::RstatDenied) begin
								res_vld  = 1'b1;
								res_stat = rpchc_pkg::STATUS_DENIED;
							end else if (word != rpchc_pkg::RstatAccepted) begin
								res_vld = 1'b1;
							end else begin
								stage_d = rpchc_pkg::STAGE_FLAVOR;
							end
						end
						rpchc_pkg::STAGE_FLAVOR: begin
							stage_d = rpchc_pkg::STAGE_VLEN;
						end
						rpchc_pkg::STAGE_VLEN: begin
							if (padded == '0) begin
								stage_d = rpchc_pkg::STAGE_ACCEPT;
							end else begin
								skip_d  = padded;
								stage_d = rpchc_pkg::STAGE_SKIP;
							end
						end
						rpchc_pkg::STAGE_ACCEPT: begin
							res_vld  = 1'b1;
							res_stat = (word != rpchc_pkg::AcceptSuccess) ?
								rpchc_pkg::STATUS_ACCEPT_FAIL : rpchc_pkg::STATUS_OK;
						end
						default: begin
							res_vld = 1'b1;
						end
					endcase
				end
				if (!res_vld && item.last_byte) begin
					res_vld  = 1'b1;
					res_stat = rpchc_pkg::STATUS_MALFORMED;
				end
			end
			if (res_vld) decided_d = 1'b1;
		end
		if (item.last_byte) begin
			stage_d   = rpchc_pkg::STAGE_XID;
			asm_d     = '0;
			biw_d     = 2'd0;
			skip_d    = '0;
			pos_d     = '0;
			decided_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= rpchc_pkg::STAGE_XID;
			asm_q     <= '0;
			biw_q     <= 2'd0;
			skip_q    <= '0;
			pos_q     <= '0;
			decided_q <= 1'b0;
		end else if (advance) begin
			stage_q   <= stage_d;
			asm_q     <= asm_d;
			biw_q     <= biw_d;
			skip_q    <= skip_d;
			pos_q     <= pos_d;
			decided_q <= decided_d;
		end
	end

	assign result.valid       = item.data_valid && res_vld;
	assign result.status      = res_stat;
	assign result.body_offset = (res_stat == rpchc_pkg::STATUS_OK) ?
		pos_ext[rpchc_pkg::OffsetW-1:0] : '0;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.last_byte |=> !decided_q && pos_q == '0 &&
			stage_q == rpchc_pkg::STAGE_XID)
		else $error("message state not cleared after last byte");

	a_result_sets_decided: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.valid && !item.last_byte |=> decided_q)
		else $error("decision not recorded after a result");

	a_skip_word_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == rpchc_pkg::STAGE_SKIP |-> biw_q == 2'd0 && skip_q != '0)
		else $error("verifier skip entered off a word boundary");

endmodule

// ----- design/rpchc_out_stage.sv -----
module rpchc_out_stage (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rpchc_pkg::result_t                   result,
	input  logic                                 load,
	output logic                                 free,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [rpchc_pkg::OutDataW-1:0]       m_axis_tdata
);

	logic                                valid_q;
	rpchc_pkg::status_t                  status_q;
	logic [rpchc_pkg::OffsetW-1:0]       offset_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= result.status;
			offset_q <= result.body_offset;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {
		{(rpchc_pkg::OutDataW - rpchc_pkg::OffsetW - rpchc_pkg::StatusW){1'b0}},
		offset_q, status_q};

endmodule

// ----- design/rpc_reply_header_checker.sv -----
// Checks the header of one ONC RPC reply message that arrives as a stream
// of bytes, one byte per item on the slave side, with tlast on the final
// byte. The checker compares the xid against the transaction id register,
// which resets to 1 and is written through cfg_wen and cfg_wdata; the user
// must write it only while no message is in flight, as the block does not
// enforce this. At most one item per message leaves on the master side,
// carrying the status and, on success, the byte offset of the body.
// Bytes that follow a decision are consumed up to tlast with no output.
// An accepted byte is decoded from the input register; a result that
// decides the message goes to the output register. One byte is accepted
// every cycle while no result waits on a full output register; the header
// decode is a single pass of logic between the input and result registers.
// When the receiver stalls, bytes that decide nothing keep flowing, and
// the input side stops only when a second result would have to wait.
// Reset clears the message state and both registers and sets the xid
// register to 1; no clearing pass is needed.
module rpc_reply_header_checker #(
	parameter int unsigned MAX_REPLY_BYTES = rpchc_pkg::MaxReplyBytes
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [rpchc_pkg::XidW-1:0]           cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// data_byte
	input  logic [rpchc_pkg::ByteW-1:0]          s_axis_tdata,
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// status[1:0], body_offset[18:2], zero fill up to bit 23
	output logic [rpchc_pkg::OutDataW-1:0]       m_axis_tdata
);

	logic [rpchc_pkg::XidW-1:0]  match_xid_q;
	rpchc_pkg::in_item_t         item;
	rpchc_pkg::result_t          result;
	logic                        out_free;
	logic                        advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_xid_q <= rpchc_pkg::XidReset;
		end else if (cfg_wen) begin
			match_xid_q <= cfg_wdata;
		end
	end

	assign advance = item.data_valid && (!result.valid || out_free);

	rpchc_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.advance       (advance),
		.item          (item)
	);

	rpchc_parser #(
		.MAX_REPLY_BYTES (MAX_REPLY_BYTES)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.advance      (advance),
		.match_xid    (match_xid_q),
		.result       (result)
	);

	rpchc_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.result        (result),
		.load          (advance && result.valid),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
